// ----- hdl/mlr_pkg.sv -----
package mlr_pkg;

   // Coordinate width fixes the payload structs, so it lives here.
   localparam int COORD_BITS = 6;
   localparam int DELTA_BITS = COORD_BITS + 2;
   localparam int DEC_BITS   = COORD_BITS + 4;

   localparam logic OP_MOVE = 1'b0;
   localparam logic OP_LINE = 1'b1;

   // Slope class of a run after the endpoints are ordered.
   localparam logic [2:0] CLS_VERT       = 3'd0;
   localparam logic [2:0] CLS_STEEP_UP   = 3'd1;
   localparam logic [2:0] CLS_SHALLOW_UP = 3'd2;
   localparam logic [2:0] CLS_SHALLOW_DN = 3'd3;
   localparam logic [2:0] CLS_STEEP_DN   = 3'd4;

   typedef struct packed {
      logic                  opcode;
      logic [COORD_BITS-1:0] x_coord;
      logic [COORD_BITS-1:0] y_coord;
   } req_word_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic                  last;
   } rsp_word_type;

   typedef struct packed {
      logic accept;
      logic latch;
      logic setup;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic len_zero;
      logic last_pixel;
      logic out_busy;
   } status_type;

endpackage

// ----- hdl/mlr_ctrl.sv -----
module mlr_ctrl
   import mlr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_opcode,
   output logic       req_ready,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && req_opcode == OP_LINE) begin
               cmd.latch = 1'b1;
               state_in  = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = status.len_zero ? ST_IDLE : ST_RUN;
         end
         ST_RUN: begin
            // A pixel moves into the output register whenever it is free or its word is taken.
            cmd.step = !status.out_busy || rsp_ready;
            if (cmd.step && status.last_pixel) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/mlr_datapath.sv -----
module mlr_datapath
   import mlr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  req_word_type req_word,
   input  cmd_type      cmd,
   output status_type   status,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   logic [COORD_BITS-1:0] cur_x_ff, cur_y_ff;
   logic [COORD_BITS-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic [2:0]            cls_ff, cls_in;
   logic signed [DEC_BITS-1:0] d_ff, d0_in;
   logic signed [DEC_BITS-1:0] inc_a_ff, inc_a_in, inc_b_ff, inc_b_in;
   logic [COORD_BITS-1:0] cnt_ff, len_in;
   logic                  rsp_valid_ff;
   rsp_word_type          rsp_word_ff;

   logic                  swap;
   logic signed [DELTA_BITS-1:0] dx, dy, neg_dx;
   logic signed [DEC_BITS-1:0]   dxw, dyw;
   logic                  take;
   logic                  d_neg, d_zero;

   // Order the endpoints: smaller x first, and smaller y first on a vertical.
   assign swap = (cur_x_ff > req_word.x_coord) ||
                 (cur_x_ff == req_word.x_coord && cur_y_ff > req_word.y_coord);

   assign dx     = $signed({2'b00, ex_ff}) - $signed({2'b00, sx_ff});
   assign dy     = $signed({2'b00, ey_ff}) - $signed({2'b00, sy_ff});
   assign neg_dx = -dx;
   assign dxw    = DEC_BITS'(dx);
   assign dyw    = DEC_BITS'(dy);

   always_comb begin
      cls_in   = CLS_VERT;
      d0_in    = '0;
      inc_a_in = '0;
      inc_b_in = '0;
      len_in   = dy[COORD_BITS-1:0];
      if (dx == '0) begin
         cls_in = CLS_VERT;
      end else if (dy > dx) begin
         cls_in   = CLS_STEEP_UP;
         d0_in    = (dxw <<< 1) - dyw;
         inc_a_in = (dxw <<< 1) - (dyw <<< 1);
         inc_b_in = dxw <<< 1;
      end else if (!dy[DELTA_BITS-1]) begin
         cls_in   = CLS_SHALLOW_UP;
         d0_in    = dxw - (dyw <<< 1);
         inc_a_in = (dxw <<< 1) - (dyw <<< 1);
         inc_b_in = -(dyw <<< 1);
         len_in   = dx[COORD_BITS-1:0];
      end else if (dy >= neg_dx) begin
         cls_in   = CLS_SHALLOW_DN;
         d0_in    = -dxw - (dyw <<< 1);
         inc_a_in = -(dxw <<< 1) - (dyw <<< 1);
         inc_b_in = -(dyw <<< 1);
         len_in   = dx[COORD_BITS-1:0];
      end else begin
         cls_in   = CLS_STEEP_DN;
         d0_in    = -(dxw <<< 1) - dyw;
         inc_a_in = -(dxw <<< 1) - (dyw <<< 1);
         inc_b_in = -(dxw <<< 1);
         len_in   = COORD_BITS'(-dy);
      end
   end

   assign d_neg  = d_ff[DEC_BITS-1];
   assign d_zero = (d_ff == '0);

   always_comb begin
      case (cls_ff)
         CLS_STEEP_UP:   take = !d_neg;
         CLS_SHALLOW_UP: take = d_neg;
         CLS_SHALLOW_DN: take = !d_neg && !d_zero;
         CLS_STEEP_DN:   take = d_neg;
         default:        take = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= '0;
         cur_y_ff <= '0;
      end else if (cmd.accept) begin
         cur_x_ff <= req_word.x_coord;
         cur_y_ff <= req_word.y_coord;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         sx_ff <= swap ? req_word.x_coord : cur_x_ff;
         sy_ff <= swap ? req_word.y_coord : cur_y_ff;
         ex_ff <= swap ? cur_x_ff : req_word.x_coord;
         ey_ff <= swap ? cur_y_ff : req_word.y_coord;
      end else if (cmd.step) begin
         case (cls_ff)
            CLS_STEEP_UP: begin
               sx_ff <= sx_ff + COORD_BITS'(take);
               sy_ff <= sy_ff + COORD_BITS'(1);
            end
            CLS_SHALLOW_UP: begin
               sx_ff <= sx_ff + COORD_BITS'(1);
               sy_ff <= sy_ff + COORD_BITS'(take);
            end
            CLS_SHALLOW_DN: begin
               sx_ff <= sx_ff + COORD_BITS'(1);
               sy_ff <= sy_ff - COORD_BITS'(take);
            end
            CLS_STEEP_DN: begin
               sx_ff <= sx_ff + COORD_BITS'(take);
               sy_ff <= sy_ff - COORD_BITS'(1);
            end
            default: begin
               sy_ff <= sy_ff + COORD_BITS'(1);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         cls_ff   <= cls_in;
         d_ff     <= d0_in;
         inc_a_ff <= inc_a_in;
         inc_b_ff <= inc_b_in;
         cnt_ff   <= len_in;
      end else if (cmd.step) begin
         d_ff   <= d_ff + (take ? inc_a_ff : inc_b_ff);
         cnt_ff <= cnt_ff - COORD_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         rsp_word_ff.pixel_x <= sx_ff;
         rsp_word_ff.pixel_y <= sy_ff;
         rsp_word_ff.last    <= (cnt_ff == COORD_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.len_zero   = (len_in == '0);
   assign status.last_pixel = (cnt_ff == COORD_BITS'(1));
   assign status.out_busy   = rsp_valid_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- hdl/midpoint_line_rasterizer.sv -----
// Midpoint line rasterizer.
// The request channel (req_valid, req_ready, req_word) takes one command word:
// a move sets the current point, a line draws from the current point to the
// given end point and then makes that point current. The response channel
// (rsp_valid, rsp_ready, rsp_word) returns one word per pixel, with last set
// on the final pixel of a run. The far endpoint of a run is not drawn, and a
// line to the current point produces no pixels.
// A move only updates the current point. A line first latches the ordered
// endpoints, then has a setup step for the deltas, slope class and decision
// value, then walks the run at one pixel per cycle while the receiver keeps
// up, with one decision variable update per pixel; a run has L pixels (L is
// the major-axis length, at most 63). The first pixel word is registered in
// the output register after the latch, the setup step and its first walk step.
// The next command is accepted as soon as the last pixel of a run has entered
// the output register, even while that pixel still waits for rsp_ready.
// When the receiver stalls, the walk pauses and the pending word is held.
// Synchronous reset clears the current point to the origin, empties the
// output register and returns the controller to idle.
module midpoint_line_rasterizer
   import mlr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   // Commands flow from the controller to the datapath; status flows back.
   cmd_type    cmd;
   status_type status;

   mlr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_word.opcode),
      .req_ready  (req_ready),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   mlr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

// ----- hdl/mlr_checker.sv -----
module mlr_checker
   import mlr_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_word
);

   // A stalled response word holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("stalled response word changed");

   // Reset leaves the output empty and the block ready for a command.
   assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   // While a non-final pixel is shown, the run is still in progress.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.last |-> !req_ready)
      else $error("command accepted in the middle of a run");

   // A line command occupies the block for at least its setup.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_word.opcode == OP_LINE |=> !req_ready)
      else $error("line command did not enter setup");

   // A move command produces no pixels and leaves the block ready.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_word.opcode == OP_MOVE |=> req_ready)
      else $error("move command stalled the block");

endmodule

bind midpoint_line_rasterizer mlr_checker u_mlr_checker (.*);

// ----- sim/midpoint_line_rasterizer_tb.sv -----
`timescale 1ns / 100ps

// Testbench for the midpoint line rasterizer.
// An initial block builds the whole command list up front: a short directed
// list of corner-case lines and moves, then random ones. A clocked driver offers
// the commands in bursts with random gaps, and a clocked receiver stalls the
// pixel channel on a changing pattern of its own. The monitor runs a
// line-drawing predictor on every accepted command word and compares each
// accepted pixel word, field by field, against the oldest predicted pixel.
module midpoint_line_rasterizer_tb;
   import mlr_pkg::*;

   localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
   localparam int RANDOM_CMDS = 235;
   // Cycles without any handshake before the run is declared hung. The longest
   // legal quiet stretch is the receiver's long hold-off.
   localparam int IDLE_LIMIT  = 3000;
   localparam int LONG_HOLD   = 400;
   // A full-length run plus its latch and setup cycles, with margin.
   localparam int TAIL_CYCLES = 80;
   localparam int PRINT_LIMIT = 40;

   // One pending command word, plus a flag that makes the driver wait until
   // every predicted pixel has come back before it offers this word.
   typedef struct {
      req_word_type word;
      bit           drain_first;
   } command_entry_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   command_entry_type command_queue[$];
   rsp_word_type      expected_pixels[$];

   // Current point as the predictor sees it; it follows every accepted word.
   logic [COORD_BITS-1:0] pen_x = '0;
   logic [COORD_BITS-1:0] pen_y = '0;
   // Current point as the stimulus builder sees it, used to aim nearby lines.
   int plan_x = 0;
   int plan_y = 0;

   int  total_commands = 0;
   int  commands_accepted = 0;
   int  lines_accepted = 0;
   int  moves_accepted = 0;
   int  empty_lines = 0;
   int  pixels_checked = 0;
   int  error_count = 0;
   int  idle_cycles = 0;
   int  drain_pauses = 0;
   bit  req_taken = 1'b0;
   bit  long_hold_done = 1'b0;

   midpoint_line_rasterizer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic rsp_word_type make_pixel(int x, int y, bit final_pixel);
      rsp_word_type w;
      w.pixel_x = x[COORD_BITS-1:0];
      w.pixel_y = y[COORD_BITS-1:0];
      w.last    = final_pixel;
      return w;
   endfunction

   // Walks one command word the way the block should: a move only updates the
   // current point, a line queues its pixels in output order. The run always
   // starts at the endpoint with the smaller x (smaller y when vertical), and
   // the far endpoint is never emitted. The decision value is kept as an
   // integer scaled by two, so every comparison is exact.
   task automatic rasterize_command(input req_word_type cmd);
      int         x0, y0, x1, y1, dx, dy, dec, px, py, run_len, k, swap_tmp;
      logic [2:0] slope_class;
      x0 = pen_x;
      y0 = pen_y;
      x1 = cmd.x_coord;
      y1 = cmd.y_coord;
      pen_x = cmd.x_coord;
      pen_y = cmd.y_coord;
      if (cmd.opcode == OP_MOVE) begin
         moves_accepted++;
         return;
      end
      lines_accepted++;
      if (x0 == x1 && y0 == y1) begin
         empty_lines++;
      end

      if (x0 > x1) begin
         swap_tmp = x0; x0 = x1; x1 = swap_tmp;
         swap_tmp = y0; y0 = y1; y1 = swap_tmp;
      end
      dx = x1 - x0;
      dy = y1 - y0;
      if (dx == 0) begin
         slope_class = CLS_VERT;
      end else if (dy > dx) begin
         slope_class = CLS_STEEP_UP;
      end else if (dy >= 0) begin
         slope_class = CLS_SHALLOW_UP;
      end else if (dy >= -dx) begin
         slope_class = CLS_SHALLOW_DN;
      end else begin
         slope_class = CLS_STEEP_DN;
      end

      px = x0;
      py = y0;
      case (slope_class)
         CLS_VERT: begin
            // Vertical runs go upward from the lower endpoint.
            py = (y0 < y1) ? y0 : y1;
            run_len = (y0 < y1) ? (y1 - y0) : (y0 - y1);
            for (k = 0; k < run_len; k++) begin
               expected_pixels.push_back(make_pixel(px, py + k, k == run_len - 1));
            end
         end
         CLS_STEEP_UP: begin
            dec = 2 * dx - dy;
            run_len = dy;
            for (k = 0; k < run_len; k++) begin
               expected_pixels.push_back(make_pixel(px, py, k == run_len - 1));
               if (dec >= 0) begin
                  px++;
                  dec += 2 * dx - 2 * dy;
               end else begin
                  dec += 2 * dx;
               end
               py++;
            end
         end
         CLS_SHALLOW_UP: begin
            dec = dx - 2 * dy;
            run_len = dx;
            for (k = 0; k < run_len; k++) begin
               expected_pixels.push_back(make_pixel(px, py, k == run_len - 1));
               if (dec < 0) begin
                  py++;
                  dec += 2 * dx - 2 * dy;
               end else begin
                  dec -= 2 * dy;
               end
               px++;
            end
         end
         CLS_SHALLOW_DN: begin
            dec = -dx - 2 * dy;
            run_len = dx;
            for (k = 0; k < run_len; k++) begin
               expected_pixels.push_back(make_pixel(px, py, k == run_len - 1));
               if (dec > 0) begin
                  py--;
                  dec -= 2 * dx + 2 * dy;
               end else begin
                  dec -= 2 * dy;
               end
               px++;
            end
         end
         default: begin
            // Steep downward: y is the major axis and counts down.
            dec = -2 * dx - dy;
            run_len = -dy;
            for (k = 0; k < run_len; k++) begin
               expected_pixels.push_back(make_pixel(px, py, k == run_len - 1));
               if (dec < 0) begin
                  px++;
                  dec -= 2 * dx + 2 * dy;
               end else begin
                  dec -= 2 * dx;
               end
               py--;
            end
         end
      endcase
   endtask

   // Prints one line per mismatch. Only the first few are printed so that a
   // badly broken block cannot flood the log, but every one is counted.
   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("%0t ns MISMATCH: %s", $time, msg);
      end
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // Monitor and watchdog: everything is sampled at the rising edge.
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset) begin
         req_taken <= req_valid && req_ready;

         // Pixels first: a command accepted on this edge cannot have produced
         // a pixel yet, so the order of the two checks does not matter.
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("pixel word (%0d,%0d) last=%0b with none expected",
                                         rsp_word.pixel_x, rsp_word.pixel_y, rsp_word.last));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_word.pixel_x !== want.pixel_x) begin
                  report_mismatch($sformatf("pixel %0d pixel_x got %0d, expected %0d",
                                            pixels_checked, rsp_word.pixel_x, want.pixel_x));
               end
               if (rsp_word.pixel_y !== want.pixel_y) begin
                  report_mismatch($sformatf("pixel %0d pixel_y got %0d, expected %0d",
                                            pixels_checked, rsp_word.pixel_y, want.pixel_y));
               end
               if (rsp_word.last !== want.last) begin
                  report_mismatch($sformatf("pixel %0d last got %0b, expected %0b",
                                            pixels_checked, rsp_word.last, want.last));
               end
            end
            pixels_checked++;
         end

         if (req_valid && req_ready) begin
            rasterize_command(req_word);
            commands_accepted++;
         end

         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles, %0d of %0d commands taken",
                     IDLE_LIMIT, commands_accepted, total_commands);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Command driver: changes its outputs at the falling edge only.
   // ---------------------------------------------------------------------

   int burst_left = 0;
   int gap_left   = 0;

   always @(negedge clock) begin
      command_entry_type entry;
      bit [31:0] rnd;
      logic [$bits(req_word_type)-1:0] junk;
      rnd  = $urandom;
      junk = rnd[$bits(req_word_type)-1:0];
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         // The previous word is gone (or there was none), so a new one may be
         // offered. Bursts are mostly short; some are long enough to run the
         // block back to back, and some gaps are zero to join bursts.
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         end
         if (burst_left == 0) begin
            gap_left--;
            req_valid <= 1'b0;
            req_word  <= junk;
         end else if (command_queue.size() != 0 &&
                      (!command_queue[0].drain_first || expected_pixels.size() == 0)) begin
            entry = command_queue.pop_front();
            if (entry.drain_first) begin
               drain_pauses++;
            end
            burst_left--;
            req_valid <= 1'b1;
            req_word  <= entry.word;
         end else begin
            // Either out of commands or holding until all pixels are back.
            req_valid <= 1'b0;
            req_word  <= junk;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Pixel receiver: its own randomly redrawn stall pattern, plus
   // one long hold-off once enough pixels have gone by. During that hold the
   // driver keeps offering words, so the block must fill up and drop ready.
   // ---------------------------------------------------------------------

   int hold_left    = 0;
   int pattern_mode = 0;
   int pattern_tick = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         pattern_tick++;
         if (pattern_tick % 64 == 0) begin
            pattern_mode = $urandom_range(0, 3);
         end
         if (!long_hold_done && pixels_checked >= 300) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (pattern_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 1) == 1);
               2:       rsp_ready <= (pattern_tick % 4 == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------

   task automatic push_command(input logic op, input int x, input int y, input bit drain);
      command_entry_type entry;
      entry.word.opcode  = op;
      entry.word.x_coord = x[COORD_BITS-1:0];
      entry.word.y_coord = y[COORD_BITS-1:0];
      entry.drain_first  = drain;
      command_queue.push_back(entry);
      plan_x = x;
      plan_y = y;
      total_commands++;
   endtask

   function automatic int clamp_coord(int v);
      if (v < 0) begin
         return 0;
      end
      if (v > COORD_MAX) begin
         return COORD_MAX;
      end
      return v;
   endfunction

   initial begin
      int   n, shape, nx, ny;
      logic op;

      // Directed part. Out of reset the current point is the origin, so the
      // first line has zero length and must produce nothing.
      push_command(OP_LINE, 0, 0, 1'b0);
      push_command(OP_LINE, COORD_MAX, 0, 1'b0);          // full-width horizontal
      push_command(OP_LINE, COORD_MAX, COORD_MAX, 1'b0);  // full-height vertical, upward
      push_command(OP_LINE, 0, 0, 1'b0);                  // slope 1, endpoints swapped
      push_command(OP_LINE, 0, COORD_MAX, 1'b0);          // vertical from the lower end
      push_command(OP_LINE, COORD_MAX, 0, 1'b0);          // slope exactly -1
      push_command(OP_MOVE, 10, 10, 1'b0);
      push_command(OP_LINE, 12, 40, 1'b0);                // steep upward
      push_command(OP_LINE, 40, 20, 1'b0);                // shallow downward
      push_command(OP_LINE, 45, 0, 1'b0);                 // steep downward
      push_command(OP_LINE, 5, 3, 1'b0);                  // shallow downward, swapped
      push_command(OP_LINE, 5, 3, 1'b0);                  // line to the current point
      push_command(OP_MOVE, COORD_MAX, COORD_MAX, 1'b0);
      push_command(OP_LINE, COORD_MAX - 1, 0, 1'b0);      // steep upward, swapped
      push_command(OP_LINE, 0, 1, 1'b0);
      push_command(OP_LINE, 1, COORD_MAX, 1'b0);          // steep upward, nearly vertical
      push_command(OP_MOVE, 0, 0, 1'b0);
      push_command(OP_LINE, 1, 0, 1'b0);                  // single pixel, horizontal
      push_command(OP_LINE, 1, 1, 1'b0);                  // single pixel, vertical
      push_command(OP_LINE, 2, 2, 1'b0);                  // single pixel, diagonal
      push_command(OP_MOVE, 21, 42, 1'b0);
      push_command(OP_LINE, 42, 21, 1'b0);                // slope -1 on alternating bits
      push_command(OP_MOVE, 0, 0, 1'b0);
      push_command(OP_LINE, COORD_MAX, 32, 1'b0);         // shallow upward, odd slope

      // Random part. Most words are lines; shapes lean toward the cases that
      // matter: short lines near the current point, axis-aligned lines,
      // lines to a corner and lines to the current point. The first
      // random word and one in the middle wait for the block to drain.
      for (n = 0; n < RANDOM_CMDS; n++) begin
         op    = ($urandom_range(0, 99) < 18) ? OP_MOVE : OP_LINE;
         shape = $urandom_range(0, 15);
         nx    = $urandom_range(0, COORD_MAX);
         ny    = $urandom_range(0, COORD_MAX);
         if (shape == 0) begin
            nx = plan_x;
            ny = plan_y;
         end else if (shape <= 4) begin
            nx = clamp_coord(plan_x + $urandom_range(0, 8) - 4);
            ny = clamp_coord(plan_y + $urandom_range(0, 8) - 4);
         end else if (shape == 5) begin
            if ($urandom_range(0, 1) == 0) begin
               nx = plan_x;
            end else begin
               ny = plan_y;
            end
         end else if (shape == 6) begin
            nx = $urandom_range(0, 1) * COORD_MAX;
            ny = $urandom_range(0, 1) * COORD_MAX;
         end
         push_command(op, nx, ny, n == 0 || n == RANDOM_CMDS / 2);
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Everything accepted and every predicted pixel back, then a tail long
      // enough for a stray extra run to show up as unexpected pixels.
      while (commands_accepted < total_commands || expected_pixels.size() != 0) begin
         @(negedge clock);
      end
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Covered %0d commands: %0d lines (%0d of zero length) and %0d moves, %0d pixels.",
               commands_accepted, lines_accepted, empty_lines, moves_accepted, pixels_checked);
      $display("Receiver held off %0d cycles once; sender drained the block %0d times.",
               LONG_HOLD, drain_pauses);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/mlr_pkg.sv
hdl/mlr_ctrl.sv
hdl/mlr_datapath.sv
hdl/midpoint_line_rasterizer.sv
hdl/mlr_checker.sv
sim/midpoint_line_rasterizer_tb.sv
